>>> rtl/core/sss_pkg.sv
// Package for the sensor sample smoothing block: sizes, slot geometry and
// configuration register indexes. No dependencies.
`default_nettype none

package sss_pkg;

    localparam int NUM_CHANNELS = 2;
    localparam int NUM_AXES     = 3;

    localparam int CHANNEL_W = 1;
    localparam int AXIS_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 24;
    localparam int WEIGHT_W  = 8;

    // Slot store geometry.
    localparam int NUM_SLOTS = NUM_CHANNELS * NUM_AXES;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Signed numerator prev*w + sample, its magnitude, and the divisor w+1.
    localparam int NUM_SW = SAMPLE_W + WEIGHT_W + 1;
    localparam int NUM_W  = NUM_SW - 1;
    localparam int DEN_W  = WEIGHT_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = WEIGHT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CH0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CH1 = CFG_IDX_W'(1);

endpackage

`default_nettype wire

>>> rtl/core/sss_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sss_pkg for the dividend and divisor widths.
`default_nettype none

module sss_div (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire  [sss_pkg::NUM_W-1:0]   i_dividend,
    input  wire  [sss_pkg::DEN_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [sss_pkg::NUM_W-1:0]   o_quotient
);
    import sss_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] n_rem;

    // The dividend shifts out of the top of r_quo while quotient bits
    // shift in at the bottom.
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/core/sensor_sample_smoothing.sv
// Top level of the sensor sample smoothing block: slot store, weight
// registers, sequencer and output register. Depends on sss_pkg and sss_div.
`default_nettype none

// Smooths 24-bit signed axis samples per channel and axis slot as
// new = (prev*w + sample)/(w+1), rounded toward zero, and stores the result
// as the slot's new previous value. One sample is worked on at a time: after
// its transfer the block forms the multiply-add, then forms the magnitude and
// starts the bit-serial divider, sees the divider finish, and loads the
// output register once that register is free. A new sample is taken as soon
// as the result sits in the output register, even while that result still
// waits to be taken. A sample whose axis is out of range is taken and dropped
// with no result. The slot store is cleared by reset; weights reset to zero
// (no smoothing) and should only be written while the block is idle.
module sensor_sample_smoothing (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [sss_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [sss_pkg::CFG_DATA_W-1:0]   i_cfg_data,

    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire  [sss_pkg::CHANNEL_W-1:0]    i_channel,
    input  wire  [sss_pkg::AXIS_W-1:0]       i_axis,
    input  wire  [sss_pkg::BYTE_W-1:0]       i_byte_high,
    input  wire  [sss_pkg::BYTE_W-1:0]       i_byte_mid,
    input  wire  [sss_pkg::BYTE_W-1:0]       i_byte_low,

    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [sss_pkg::CHANNEL_W-1:0]    o_out_channel,
    output logic [sss_pkg::AXIS_W-1:0]       o_out_axis,
    output logic signed [sss_pkg::SAMPLE_W-1:0] o_filtered
);
    import sss_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [WEIGHT_W-1:0]        r_weight [NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_prev   [NUM_SLOTS];

    logic [CHANNEL_W-1:0]       r_ch;
    logic [AXIS_W-1:0]          r_ax;
    logic [SLOT_W-1:0]          r_slot;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [WEIGHT_W-1:0]        r_w;
    logic signed [NUM_SW-1:0]   r_num;
    logic                       r_neg;

    logic                       r_out_valid;
    logic [CHANNEL_W-1:0]       r_out_ch;
    logic [AXIS_W-1:0]          r_out_ax;
    logic signed [SAMPLE_W-1:0] r_out_val;

    logic                       in_xfer;
    logic                       axis_ok;
    logic [SLOT_W-1:0]          n_slot;
    logic signed [NUM_SW-1:0]   n_num;
    logic signed [NUM_SW-1:0]   abs_num;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quo;
    logic [SAMPLE_W-1:0]        quo_low;
    logic signed [SAMPLE_W-1:0] n_result;
    logic                       out_free;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != ST_IDLE);
    assign in_xfer     = i_valid && !o_stall;
    assign axis_ok     = ({1'b0, i_axis} < (AXIS_W + 1)'(NUM_AXES));
    assign n_slot      = SLOT_W'(int'(i_channel) * NUM_AXES + int'(i_axis));
    assign out_free    = !r_out_valid || !i_stall;

    // Full-width multiply-add; the product never wraps.
    assign n_num = NUM_SW'(r_prev[r_slot]) * NUM_SW'($signed({1'b0, r_w}))
                 + NUM_SW'(r_sample);

    assign abs_num   = r_num[NUM_SW-1] ? -r_num : r_num;
    assign div_start = (r_state == ST_ABS);

    sss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (abs_num[NUM_W-1:0]),
        .i_divisor  (DEN_W'(r_w) + DEN_W'(1)),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // The quotient of a weighted mean of two 24-bit values fits in 24 bits.
    assign quo_low  = div_quo[SAMPLE_W-1:0];
    assign n_result = r_neg ? $signed(-quo_low) : $signed(quo_low);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && axis_ok) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_ABS;
            ST_ABS: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_weight[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WEIGHT_CH0: r_weight[0] <= i_cfg_data;
                    CFG_WEIGHT_CH1: r_weight[1] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid    <= 1'b1;
                r_prev[r_slot] <= n_result;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch     <= i_channel;
            r_ax     <= i_axis;
            r_slot   <= n_slot;
            r_sample <= $signed({i_byte_high, i_byte_mid, i_byte_low});
            r_w      <= r_weight[i_channel];
        end
        if (r_state == ST_MUL) begin
            r_num <= n_num;
        end
        if (r_state == ST_ABS) begin
            r_neg <= r_num[NUM_SW-1];
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_ch  <= r_ch;
            r_out_ax  <= r_ax;
            r_out_val <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_channel = r_out_ch;
    assign o_out_axis    = r_out_ax;
    assign o_filtered    = r_out_val;

`ifndef NO_ASSERTIONS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && axis_ok) |=> r_state == ST_MUL)
        else $error("accepted sample did not start the sequence");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_OUT)
        else $error("result appeared without finishing a sample");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_out_axis} < (AXIS_W + 1)'(NUM_AXES))
        else $error("result for an axis out of range");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for sensor_sample_smoothing: drives axis samples and
// weight writes, predicts each filtered result and compares it on the output.
// Depends on sss_pkg and the RTL of the block.
`default_nettype none

module tb_top;

    import sss_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 45;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 250;

    localparam logic [AXIS_W-1:0]    AXIS_UNUSED     = AXIS_W'(NUM_AXES);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_WEIGHT_CH1 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = '1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = 24'h800000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG1 = 24'hFFFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO = 24'h000000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE  = 24'h000001;

    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [AXIS_W-1:0]    axis;
        logic [SAMPLE_W-1:0]  raw;
    } axis_sample_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0]       channel;
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] value;
    } filtered_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CHANNEL_W-1:0]  i_channel = '0;
    logic [AXIS_W-1:0]     i_axis = '0;
    logic [BYTE_W-1:0]     i_byte_high = '0;
    logic [BYTE_W-1:0]     i_byte_mid = '0;
    logic [BYTE_W-1:0]     i_byte_low = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [CHANNEL_W-1:0]  o_out_channel;
    logic [AXIS_W-1:0]     o_out_axis;
    logic signed [SAMPLE_W-1:0] o_filtered;

    sensor_sample_smoothing uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_axis        (i_axis),
        .i_byte_high   (i_byte_high),
        .i_byte_mid    (i_byte_mid),
        .i_byte_low    (i_byte_low),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_out_axis    (o_out_axis),
        .o_filtered    (o_filtered)
    );

    // Shadow copy of the slot store and the weight registers.
    logic signed [SAMPLE_W-1:0] slot_prev [NUM_CHANNELS][NUM_AXES] = '{default: '0};
    logic [WEIGHT_W-1:0]        channel_weight [NUM_CHANNELS] = '{default: '0};

    axis_sample_t pending_samples[$];
    filtered_t    expected_results[$];
    axis_sample_t held_sample;

    int error_count     = 0;
    int results_checked = 0;
    int samples_dropped = 0;
    int settings_run    = 0;
    int cycle_count     = 0;
    int send_gap        = 0;
    int send_calm       = 0;
    int stall_left      = 0;
    int open_left       = 0;
    int recv_calm       = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch
    // with no idling at all.
    function automatic int idle_length(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
    endfunction

    // Weighted running mean of one slot, formed at full width.
    function automatic void predict_smoothing(axis_sample_t s);
        longint prev_val, wgt, smp, acc, quo;
        filtered_t f;
        if (s.axis >= NUM_AXES || s.channel >= NUM_CHANNELS) begin
            samples_dropped++;
            return;
        end
        prev_val = slot_prev[s.channel][s.axis];
        wgt      = channel_weight[s.channel];
        smp      = $signed(s.raw);
        acc      = prev_val * wgt + smp;
        quo      = acc / (wgt + 1);
        slot_prev[s.channel][s.axis] = quo[SAMPLE_W-1:0];
        f.channel = s.channel;
        f.axis    = s.axis;
        f.value   = quo[SAMPLE_W-1:0];
        expected_results.push_back(f);
    endfunction

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) predict_smoothing(held_sample);
            if (i_valid && o_stall) begin
                // The stalled transfer keeps its payload.
            end else if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                held_sample = pending_samples.pop_front();
                i_valid     <= 1'b1;
                i_channel   <= held_sample.channel;
                i_axis      <= held_sample.axis;
                i_byte_high <= held_sample.raw[SAMPLE_W-1 -: BYTE_W];
                i_byte_mid  <= held_sample.raw[BYTE_W +: BYTE_W];
                i_byte_low  <= held_sample.raw[BYTE_W-1:0];
                send_gap = idle_length(send_calm);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        filtered_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
            open_left  = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    note_error($sformatf("unexpected result: channel %0d axis %0d value %0d",
                                         o_out_channel, o_out_axis, o_filtered));
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (o_out_channel !== want.channel || o_out_axis !== want.axis ||
                        o_filtered !== want.value) begin
                        note_error($sformatf(
                            "result %0d: want ch %0d ax %0d val %0d, got ch %0d ax %0d val %0d",
                            results_checked, want.channel, want.axis, want.value,
                            o_out_channel, o_out_axis, o_filtered));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (open_left > 0) begin
                open_left--;
                i_stall <= 1'b0;
            end else begin
                stall_left = idle_length(recv_calm);
                open_left  = $urandom_range(1, 12);
                i_stall <= (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles", cycle_count);
        $display("sensor_sample_smoothing regression: fail");
        $finish;
    end

    function automatic void queue_sample(logic [CHANNEL_W-1:0] ch, logic [AXIS_W-1:0] ax,
                                         logic [SAMPLE_W-1:0] raw);
        axis_sample_t s;
        s.channel = ch;
        s.axis    = ax;
        s.raw     = raw;
        pending_samples.push_back(s);
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_raw();
        case ($urandom_range(0, 39))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SAMPLE_NEG1;
            3: return SAMPLE_ZERO;
            4: return SAMPLE_ONE;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly single samples on random slots, some runs of a noisy but steady
    // signal around one base value on one slot so the filter settles, and a few dropped axes.
    function automatic void queue_random_phase(int target);
        int counted, run_len, r;
        logic [CHANNEL_W-1:0] ch;
        logic [AXIS_W-1:0]    ax;
        logic [SAMPLE_W-1:0]  base;
        counted = 0;
        while (counted < target) begin
            r  = $urandom_range(0, 99);
            ch = CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
            ax = AXIS_W'($urandom_range(0, NUM_AXES - 1));
            if (r < 8) begin
                queue_sample(ch, AXIS_UNUSED, random_raw());
            end else if (r < 25) begin
                run_len = $urandom_range(4, 12);
                base    = random_raw();
                for (int k = 0; k < run_len; k++) begin
                    queue_sample(ch, ax,
                                 base + SAMPLE_W'($urandom_range(0, 31)) - SAMPLE_W'(16));
                end
                counted += run_len;
            end else begin
                queue_sample(ch, ax, random_raw());
                counted++;
            end
        end
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WEIGHT_CH0) channel_weight[0] = data;
        else if (idx == CFG_WEIGHT_CH1) channel_weight[1] = data;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_weights(logic [WEIGHT_W-1:0] w0, logic [WEIGHT_W-1:0] w1);
        write_register(CFG_WEIGHT_CH0, w0);
        write_register(CFG_WEIGHT_CH1, w1);
        if ($urandom_range(0, 1) == 1) begin
            write_register(CFG_IDX_W'($urandom_range(CFG_UNUSED_LOW, CFG_UNUSED_HIGH)),
                           CFG_DATA_W'($urandom));
        end
        settings_run++;
    endtask

    // The idle check runs between edges, after every update has settled,
    // so a sample about to be driven or still in the block is always seen.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_valid || o_stall || o_valid ||
               expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [WEIGHT_W-1:0] w0_list [6];
        logic [WEIGHT_W-1:0] w1_list [6];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset weights are zero, so each result is the sample itself.
        queue_sample(1'b0, 2'd0, SAMPLE_MAX);
        queue_sample(1'b0, 2'd1, SAMPLE_MIN);
        queue_sample(1'b0, 2'd2, SAMPLE_NEG1);
        queue_sample(1'b1, 2'd0, SAMPLE_ZERO);
        queue_sample(1'b1, 2'd1, SAMPLE_ONE);
        queue_sample(1'b1, 2'd2, SAMPLE_MIN);
        queue_sample(1'b0, AXIS_UNUSED, 24'h123456);
        queue_sample(1'b1, AXIS_UNUSED, SAMPLE_MIN);
        wait_idle();
        settings_run++;

        // Extreme weights; writes to unused indexes must change nothing.
        write_register(CFG_WEIGHT_CH0, 8'd255);
        write_register(CFG_WEIGHT_CH1, 8'd1);
        write_register(CFG_UNUSED_LOW, 8'hAA);
        write_register(CFG_UNUSED_HIGH, 8'h55);
        settings_run++;

        // Products of full-scale values, and negative quotients that
        // truncate toward zero.
        queue_sample(1'b0, 2'd0, SAMPLE_MIN);
        queue_sample(1'b0, 2'd1, SAMPLE_MAX);
        queue_sample(1'b0, 2'd2, SAMPLE_MAX);
        queue_sample(1'b1, 2'd0, SAMPLE_NEG1);
        queue_sample(1'b1, 2'd0, 24'hFFFFFD);
        queue_sample(1'b1, 2'd1, SAMPLE_MAX);
        queue_sample(1'b1, 2'd2, SAMPLE_MIN);
        queue_sample(1'b1, 2'd2, SAMPLE_MAX);
        wait_idle();

        w0_list = '{8'd0, 8'd255, 8'd1, WEIGHT_W'($urandom_range(2, 254)),
                    WEIGHT_W'($urandom_range(2, 254)), 8'd255};
        w1_list = '{8'd255, 8'd0, 8'd128, WEIGHT_W'($urandom_range(2, 254)),
                    WEIGHT_W'($urandom_range(2, 254)), 8'd255};
        for (int p = 0; p < 6; p++) begin
            set_weights(w0_list[p], w1_list[p]);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        $display("Checked %0d filtered results across %0d weight settings.",
                 results_checked, settings_run);
        $display("%0d samples with an unused axis were dropped; %0d mismatches.",
                 samples_dropped, error_count);
        if (error_count == 0) begin
            $display("sensor_sample_smoothing regression: pass");
        end else begin
            $display("sensor_sample_smoothing regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
